/* design/ctmt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctmt_pkg: shared types and constants of the client traffic meter table
// Request and status codes, controller states and controller/datapath links.
// ----------------------------------------------------------------------------
package ctmt_pkg;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_DEL   = 2'd1,
    REQ_BYTES = 2'd2,
    REQ_QUERY = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_IGNORE = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_SEC,
    S_DONE
  } state_t;

  localparam int unsigned WINDOW_RESET = 32'd1000000;
  localparam int unsigned DIV_STEPS    = 64;
  // ceil(2^71 / 15625): (us >> 6) * SEC_RECIP >> 71 is exactly us / 1000000
  localparam logic [57:0] SEC_RECIP    = 58'((128'd1 << 71) / 128'd15625 + 128'd1);
  localparam int unsigned SEC_STEPS    = 4;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request
    logic exec;       // read slot and apply the quick update
    logic mul_start;  // form delta * 8000 and start rate division
    logic div_step;   // one divider bit
    logic sec_step;   // one partial product of the seconds multiply
    logic commit;     // write back query results
    logic out_load;   // load result register
  } ctmt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_rate;  // query needs a new rate
    logic need_sec;   // query needs a connected time
    logic div_done;   // divider finished
    logic sec_done;   // seconds multiply finished
  } ctmt_sts_t;

endpackage

/* design/ctmt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctmt_in_if / ctmt_out_if / ctmt_cfg_if: handshake channels
// Valid/ready channels carrying requests, results and the window register.
// ----------------------------------------------------------------------------
interface ctmt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  slot;
  logic [30:0] byte_count;
  logic [2:0]  client_kind;
  logic [7:0]  channel;
  logic [31:0] peer_ip;
  logic [15:0] peer_port;
  logic [62:0] now_us;
  modport source (output valid, req_type, slot, byte_count, client_kind, channel,
                  peer_ip, peer_port, now_us, input ready);
  modport sink (input valid, req_type, slot, byte_count, client_kind, channel,
                peer_ip, peer_port, now_us, output ready);
endinterface

interface ctmt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  result_slot;
  logic        in_use;
  logic [2:0]  kind_out;
  logic [7:0]  channel_out;
  logic [31:0] ip_out;
  logic [15:0] port_out;
  logic [43:0] connected_s;
  logic [31:0] rate_kbps;
  logic [63:0] total_bytes;
  modport source (output valid, status, result_slot, in_use, kind_out, channel_out,
                  ip_out, port_out, connected_s, rate_kbps, total_bytes, input ready);
  modport sink (input valid, status, result_slot, in_use, kind_out, channel_out,
                ip_out, port_out, connected_s, rate_kbps, total_bytes, output ready);
endinterface

interface ctmt_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* design/ctmt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctmt_ctrl: request sequencer
// Steps each request through execute, optional arithmetic and result load.
// ----------------------------------------------------------------------------
module ctmt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_busy,
  input  ctmt_pkg::ctmt_sts_t sts,
  output ctmt_pkg::ctmt_cmd_t cmd
);

  ctmt_pkg::state_t state_r, state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ctmt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // advance
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ctmt_pkg::S_IDLE: if (in_valid) state_nxt = ctmt_pkg::S_EXEC;
      ctmt_pkg::S_EXEC: begin
        if (sts.need_rate)     state_nxt = ctmt_pkg::S_MUL;
        else if (sts.need_sec) state_nxt = ctmt_pkg::S_SEC;
        else                   state_nxt = ctmt_pkg::S_DONE;
      end
      ctmt_pkg::S_MUL: state_nxt = ctmt_pkg::S_DIV;
      ctmt_pkg::S_DIV: begin
        if (sts.div_done) state_nxt = sts.need_sec ? ctmt_pkg::S_SEC : ctmt_pkg::S_DONE;
      end
      ctmt_pkg::S_SEC: if (sts.sec_done) state_nxt = ctmt_pkg::S_DONE;
      ctmt_pkg::S_DONE: if (!out_busy) state_nxt = ctmt_pkg::S_IDLE;
      default: state_nxt = ctmt_pkg::S_IDLE;
    endcase
  end

  // drive commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ctmt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ctmt_pkg::S_EXEC: cmd.exec = 1'b1;
      ctmt_pkg::S_MUL:  cmd.mul_start = 1'b1;
      ctmt_pkg::S_DIV:  cmd.div_step = 1'b1;
      ctmt_pkg::S_SEC:  cmd.sec_step = 1'b1;
      ctmt_pkg::S_DONE: begin
        cmd.commit   = !out_busy;
        cmd.out_load = !out_busy;
      end
      default: ;
    endcase
  end

endmodule

/* design/ctmt_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctmt_dp: slot table and arithmetic
// Slot registers, quick byte add, a radix-2 64-bit rate divider and a
// four-step reciprocal multiply for connected seconds.
// ----------------------------------------------------------------------------
module ctmt_dp #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ctmt_pkg::ctmt_cmd_t cmd,
  output ctmt_pkg::ctmt_sts_t sts,
  ctmt_in_if.sink             in_ch,
  ctmt_cfg_if.sink            cfg_ch,
  output logic [1:0]          r_status,
  output logic [3:0]          r_slot,
  output logic                r_used,
  output logic [2:0]          r_kind,
  output logic [7:0]          r_chan,
  output logic [31:0]         r_ip,
  output logic [15:0]         r_port,
  output logic [43:0]         r_sec,
  output logic [31:0]         r_rate,
  output logic [63:0]         r_total
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int ACC_W = 116;
  localparam logic [57:0] RECIP = ctmt_pkg::SEC_RECIP;

  logic [NUM_SLOTS-1:0] used_r;
  logic [2:0]  kind_r  [NUM_SLOTS];
  logic [7:0]  chan_r  [NUM_SLOTS];
  logic [31:0] ip_r    [NUM_SLOTS];
  logic [15:0] port_r  [NUM_SLOTS];
  logic [62:0] ctime_r [NUM_SLOTS];
  logic [63:0] total_r [NUM_SLOTS];
  logic [63:0] bbytes_r[NUM_SLOTS];
  logic [62:0] btime_r [NUM_SLOTS];
  logic [31:0] rate_r  [NUM_SLOTS];
  logic [31:0] win_r;

  // captured request
  logic [1:0]  req_r;
  logic [3:0]  slot_r;
  logic [30:0] cnt_r;
  logic [2:0]  ckind_r;
  logic [7:0]  cchan_r;
  logic [31:0] cip_r;
  logic [15:0] cport_r;
  logic [62:0] now_r;

  // working values
  logic [SW-1:0]    idx_r;
  logic             need_rate_r, need_sec_r, full_r;
  logic [63:0]      dt_r, delta_r, b_r;
  logic [63:0]      num_r, den_r, rem_r;
  logic [6:0]       cnt_div_r;
  logic [31:0]      qrate_r;
  logic [56:0]      sec_y_r;
  logic [ACC_W-1:0] sec_acc_r;
  logic [2:0]       sec_cnt_r;

  // first free slot
  logic [SW-1:0] free_idx;
  logic          free_any;
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = SW'(i);
        free_any = 1'b1;
      end
    end
  end

  logic          in_range;
  logic [SW-1:0] sidx;
  logic [31:0]   win_eff;
  logic [62:0]   base_dt, conn_dt;
  logic          query_hit, rate_due, sec_due;
  assign in_range = 32'(slot_r) < 32'(NUM_SLOTS);
  assign sidx     = slot_r[SW-1:0];
  assign win_eff  = (win_r == '0) ? 32'd1 : win_r;
  assign cfg_ch.ready = 1'b1;

  // query decisions from the captured request and the slot table
  assign query_hit = req_r == ctmt_pkg::REQ_QUERY && in_range && used_r[sidx];
  assign base_dt   = now_r - btime_r[sidx];
  assign conn_dt   = now_r - ctime_r[sidx];
  assign rate_due  = query_hit && now_r >= btime_r[sidx] && 64'(base_dt) >= 64'(win_eff);
  assign sec_due   = query_hit && now_r >= ctime_r[sidx];

  assign sts.need_rate = rate_due;
  assign sts.need_sec  = sec_due;
  assign sts.div_done  = (cnt_div_r == 7'(ctmt_pkg::DIV_STEPS));
  assign sts.sec_done  = (sec_cnt_r == 3'(ctmt_pkg::SEC_STEPS));

  // one restoring division bit
  logic [64:0] rem_sh;
  logic        ge;
  assign rem_sh = {rem_r, num_r[63]};
  assign ge     = rem_sh >= {1'b0, den_r};

  // one 32x32 partial product of (us >> 6) * RECIP
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      pp;
  logic [ACC_W-1:0] pp_sh;
  always_comb begin
    case (sec_cnt_r)
      3'd0: begin
        mul_a = sec_y_r[31:0];
        mul_b = RECIP[31:0];
      end
      3'd1: begin
        mul_a = sec_y_r[31:0];
        mul_b = 32'(RECIP[57:32]);
      end
      3'd2: begin
        mul_a = 32'(sec_y_r[56:32]);
        mul_b = RECIP[31:0];
      end
      default: begin
        mul_a = 32'(sec_y_r[56:32]);
        mul_b = 32'(RECIP[57:32]);
      end
    endcase
    pp = {32'd0, mul_a} * {32'd0, mul_b};
    case (sec_cnt_r)
      3'd0:    pp_sh = ACC_W'(pp);
      3'd3:    pp_sh = ACC_W'(pp) << 64;
      default: pp_sh = ACC_W'(pp) << 32;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= ctmt_pkg::WINDOW_RESET;
    end else if (cfg_ch.valid) begin
      win_r <= cfg_ch.data;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.exec) begin
      if (req_r == ctmt_pkg::REQ_ADD && free_any) used_r[free_idx] <= 1'b1;
      else if (req_r == ctmt_pkg::REQ_DEL && in_range) used_r[sidx] <= 1'b0;
    end
  end

  // byte totals, rate fields; totals reset to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        total_r[i]  <= '0;
        bbytes_r[i] <= '0;
        rate_r[i]   <= '0;
      end
    end else if (cmd.exec && req_r == ctmt_pkg::REQ_ADD && free_any) begin
      total_r[free_idx]  <= '0;
      bbytes_r[free_idx] <= '0;
      rate_r[free_idx]   <= '0;
    end else if (cmd.exec && req_r == ctmt_pkg::REQ_BYTES && in_range && cnt_r != '0) begin
      total_r[sidx] <= total_r[sidx] + 64'(cnt_r);
    end else if (cmd.commit && req_r == ctmt_pkg::REQ_QUERY && need_rate_r) begin
      rate_r[idx_r]   <= qrate_r;
      bbytes_r[idx_r] <= b_r;
    end
  end

  // client info and times
  always_ff @(posedge clk) begin
    if (cmd.exec && req_r == ctmt_pkg::REQ_ADD && free_any) begin
      kind_r[free_idx]  <= ckind_r;
      chan_r[free_idx]  <= cchan_r;
      ip_r[free_idx]    <= cip_r;
      port_r[free_idx]  <= cport_r;
      ctime_r[free_idx] <= now_r;
      btime_r[free_idx] <= now_r;
    end else if (cmd.commit && req_r == ctmt_pkg::REQ_QUERY && need_rate_r) begin
      btime_r[idx_r] <= now_r;
    end
  end

  // capture, execute, divide, multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_rate_r <= 1'b0;
      need_sec_r  <= 1'b0;
      full_r      <= 1'b0;
      cnt_div_r   <= '0;
      sec_cnt_r   <= '0;
    end else begin
      if (cmd.load) begin
        req_r   <= in_ch.req_type;
        slot_r  <= in_ch.slot;
        cnt_r   <= in_ch.byte_count;
        ckind_r <= in_ch.client_kind;
        cchan_r <= in_ch.channel;
        cip_r   <= in_ch.peer_ip;
        cport_r <= in_ch.peer_port;
        now_r   <= in_ch.now_us;
      end
      if (cmd.exec) begin
        idx_r       <= (req_r == ctmt_pkg::REQ_ADD) ? free_idx : sidx;
        full_r      <= req_r == ctmt_pkg::REQ_ADD && !free_any;
        b_r         <= total_r[sidx];
        delta_r     <= total_r[sidx] - bbytes_r[sidx];
        dt_r        <= 64'(base_dt);
        need_rate_r <= rate_due;
        need_sec_r  <= sec_due;
        cnt_div_r   <= 7'(ctmt_pkg::DIV_STEPS);
        qrate_r     <= rate_r[sidx];
        sec_y_r     <= conn_dt[62:6];
        sec_acc_r   <= '0;
        sec_cnt_r   <= '0;
      end
      // delta * 8000 = delta * 8192 - delta * 128 - delta * 64, mod 2^64
      if (cmd.mul_start) begin
        num_r     <= (delta_r << 13) - (delta_r << 7) - (delta_r << 6);
        den_r     <= dt_r;
        rem_r     <= '0;
        cnt_div_r <= '0;
      end
      if (cmd.div_step) begin
        if (!sts.div_done) begin
          num_r     <= {num_r[62:0], ge};
          rem_r     <= ge ? 64'(rem_sh - {1'b0, den_r}) : rem_sh[63:0];
          cnt_div_r <= cnt_div_r + 7'd1;
        end else begin
          qrate_r <= num_r[31:0];
        end
      end
      if (cmd.sec_step && !sts.sec_done) begin
        sec_acc_r <= sec_acc_r + pp_sh;
        sec_cnt_r <= sec_cnt_r + 3'd1;
      end
    end
  end

  // build result (valid in S_DONE)
  always_comb begin
    r_status = ctmt_pkg::ST_OK;
    r_slot   = '0;
    r_used   = 1'b0;
    r_kind   = '0;
    r_chan   = '0;
    r_ip     = '0;
    r_port   = '0;
    r_sec    = '0;
    r_rate   = '0;
    r_total  = '0;
    if (req_r == ctmt_pkg::REQ_ADD) begin
      if (full_r) begin
        r_status = ctmt_pkg::ST_FULL;
      end else begin
        r_slot = 4'(idx_r);
        r_used = 1'b1;
        r_kind = kind_r[idx_r];
        r_chan = chan_r[idx_r];
        r_ip   = ip_r[idx_r];
        r_port = port_r[idx_r];
      end
    end else if (!in_range || (req_r == ctmt_pkg::REQ_BYTES && cnt_r == '0)) begin
      r_status = ctmt_pkg::ST_IGNORE;
    end else if (req_r == ctmt_pkg::REQ_DEL) begin
      r_slot = slot_r;
    end else if (req_r == ctmt_pkg::REQ_BYTES) begin
      r_slot  = slot_r;
      r_used  = used_r[idx_r];
      r_total = total_r[idx_r];
    end else if (!used_r[idx_r]) begin
      r_status = ctmt_pkg::ST_UNUSED;
      r_slot   = slot_r;
    end else begin
      r_slot  = slot_r;
      r_used  = 1'b1;
      r_kind  = kind_r[idx_r];
      r_chan  = chan_r[idx_r];
      r_ip    = ip_r[idx_r];
      r_port  = port_r[idx_r];
      // quotient sits above the 71 fraction bits of the reciprocal product
      r_sec   = need_sec_r ? sec_acc_r[114:71] : '0;
      r_rate  = qrate_r;
      r_total = b_r;
    end
  end

endmodule

/* design/client_traffic_meter_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// client_traffic_meter_table: client slot table with byte and rate metering
// Usage:
//   in_*  : one request per handshake (add, delete, bytes, query).
//   out_* : exactly one result per request, held until out_ready.
//   cfg_* : rate window in microseconds; write only while idle.
// Sequencing: one request at a time. Add, delete, bytes and ignored
//   requests pass through capture, execute and result register load
//   after accept. A query that needs the connected time adds the
//   four-step reciprocal multiply; one that also recomputes the rate adds
//   the multiply-start state and the bit-serial 64-bit divider.
//   Without result stalls, the divider sets the worst-case request spacing.
// Reset: rst_n clears all slots to free, totals and rates to zero, and the
//   window to 1000000 us.
// Stall: a result waiting on out_ready holds the result register; the next
//   request may be accepted meanwhile, and its result waits in the last
//   sequencer state until the register is free.
// ----------------------------------------------------------------------------
module client_traffic_meter_table #(
  parameter int NUM_SLOTS = 16
) (
  input  logic clk,
  input  logic rst_n,
  ctmt_in_if.sink    in_ch,
  ctmt_out_if.source out_ch,
  ctmt_cfg_if.sink   cfg_ch
);

  ctmt_pkg::ctmt_cmd_t cmd;
  ctmt_pkg::ctmt_sts_t sts;
  logic        out_valid_r;
  logic [1:0]  r_status;
  logic [3:0]  r_slot;
  logic        r_used;
  logic [2:0]  r_kind;
  logic [7:0]  r_chan;
  logic [31:0] r_ip;
  logic [15:0] r_port;
  logic [43:0] r_sec;
  logic [31:0] r_rate;
  logic [63:0] r_total;

  ctmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_busy (out_valid_r && !out_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ctmt_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_ch(in_ch), .cfg_ch(cfg_ch),
    .r_status(r_status), .r_slot(r_slot), .r_used(r_used), .r_kind(r_kind),
    .r_chan(r_chan), .r_ip(r_ip), .r_port(r_port), .r_sec(r_sec),
    .r_rate(r_rate), .r_total(r_total)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.status      <= r_status;
      out_ch.result_slot <= r_slot;
      out_ch.in_use      <= r_used;
      out_ch.kind_out    <= r_kind;
      out_ch.channel_out <= r_chan;
      out_ch.ip_out      <= r_ip;
      out_ch.port_out    <= r_port;
      out_ch.connected_s <= r_sec;
      out_ch.rate_kbps   <= r_rate;
      out_ch.total_bytes <= r_total;
    end
  end
  assign out_ch.valid = out_valid_r;

  // load only when the register is free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ch.ready))
    else $error("result overwritten");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.exec, cmd.mul_start, cmd.out_load}))
    else $error("overlapping commands");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> cmd.exec)
    else $error("accepted request not executed");

endmodule

/* verif/client_traffic_meter_table_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// client_traffic_meter_table_test: self-checking bench for the meter table
// Drives add, delete, bytes and query requests with random gaps and result
// back-pressure, predicts every result from a local copy of the slot table,
// and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module client_traffic_meter_table_test;

  localparam int SLOTS = 16;
  localparam logic [62:0] NOW_MASK = {63{1'b1}};

  typedef struct {
    ctmt_pkg::req_t req;
    logic [3:0]  slot;
    logic [30:0] count;
    logic [2:0]  kind;
    logic [7:0]  chan;
    logic [31:0] ip;
    logic [15:0] port;
    logic [62:0] now;
  } meter_req_t;

  typedef struct {
    ctmt_pkg::status_t status;
    logic [3:0]  slot;
    logic        in_use;
    logic [2:0]  kind;
    logic [7:0]  chan;
    logic [31:0] ip;
    logic [15:0] port;
    logic [43:0] secs;
    logic [31:0] rate;
    logic [63:0] total;
  } meter_res_t;

  logic clk;
  logic rst_n;

  ctmt_in_if  in_ch();
  ctmt_out_if out_ch();
  ctmt_cfg_if cfg_ch();

  client_traffic_meter_table #(.NUM_SLOTS(SLOTS)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow slot table
  logic [31:0] win_us;
  logic        tb_used  [SLOTS];
  logic [2:0]  tb_kind  [SLOTS];
  logic [7:0]  tb_chan  [SLOTS];
  logic [31:0] tb_ip    [SLOTS];
  logic [15:0] tb_port  [SLOTS];
  logic [63:0] tb_conn  [SLOTS];
  logic [63:0] tb_total [SLOTS];
  logic [63:0] tb_bbase [SLOTS];
  logic [63:0] tb_tbase [SLOTS];
  logic [31:0] tb_rate  [SLOTS];

  meter_res_t pending_results[$];
  int         errors;
  int         hold_off_cycles;
  logic [62:0] cur_now;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("client_traffic_meter_table_test failed");
    $finish;
  end

  // compute the result of one request and update the shadow table
  function automatic meter_res_t predict_result(meter_req_t r);
    meter_res_t res;
    int         idx;
    logic [63:0] win, dt, now64;
    res = '{status: ctmt_pkg::ST_OK, default: '0};
    now64 = {1'b0, r.now};
    if (r.req == ctmt_pkg::REQ_ADD) begin
      idx = -1;
      for (int i = SLOTS - 1; i >= 0; i--) if (!tb_used[i]) idx = i;
      if (idx < 0) begin
        res.status = ctmt_pkg::ST_FULL;
        return res;
      end
      tb_used[idx] = 1'b1;
      tb_kind[idx] = r.kind;
      tb_chan[idx] = r.chan;
      tb_ip[idx]   = r.ip;
      tb_port[idx] = r.port;
      tb_conn[idx] = now64;
      tb_tbase[idx] = now64;
      tb_total[idx] = '0;
      tb_bbase[idx] = '0;
      tb_rate[idx]  = '0;
      res.slot = 4'(idx);
      res.in_use = 1'b1;
      res.kind = r.kind;
      res.chan = r.chan;
      res.ip = r.ip;
      res.port = r.port;
      return res;
    end
    if (r.slot >= SLOTS || (r.req == ctmt_pkg::REQ_BYTES && r.count == 0)) begin
      res.status = ctmt_pkg::ST_IGNORE;
      return res;
    end
    idx = r.slot;
    res.slot = r.slot;
    if (r.req == ctmt_pkg::REQ_DEL) begin
      tb_used[idx] = 1'b0;
      return res;
    end
    if (r.req == ctmt_pkg::REQ_BYTES) begin
      tb_total[idx] = tb_total[idx] + 64'(r.count);
      res.in_use = tb_used[idx];
      res.total = tb_total[idx];
      return res;
    end
    if (!tb_used[idx]) begin
      res.status = ctmt_pkg::ST_UNUSED;
      return res;
    end
    win = (win_us == 0) ? 64'd1 : 64'(win_us);
    if (now64 >= tb_tbase[idx]) begin
      dt = now64 - tb_tbase[idx];
      if (dt >= win) begin
        tb_rate[idx]  = 32'(((tb_total[idx] - tb_bbase[idx]) * 64'd8000) / dt);
        tb_bbase[idx] = tb_total[idx];
        tb_tbase[idx] = now64;
      end
    end
    res.in_use = 1'b1;
    res.kind = tb_kind[idx];
    res.chan = tb_chan[idx];
    res.ip = tb_ip[idx];
    res.port = tb_port[idx];
    if (now64 >= tb_conn[idx]) res.secs = 44'((now64 - tb_conn[idx]) / 64'd1000000);
    res.rate = tb_rate[idx];
    res.total = tb_total[idx];
    return res;
  endfunction

  // drop valid before any wait that is not a back-to-back request
  task automatic in_idle();
    if (in_ch.valid) in_ch.valid <= 1'b0;
  endtask

  // offer one request, hold until accepted, then record its expected result
  task automatic send_req(meter_req_t r, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_idle();
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= r.req;
    in_ch.slot        <= r.slot;
    in_ch.byte_count  <= r.count;
    in_ch.client_kind <= r.kind;
    in_ch.channel     <= r.chan;
    in_ch.peer_ip     <= r.ip;
    in_ch.peer_port   <= r.port;
    in_ch.now_us      <= r.now;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_result(r));
  endtask

  // wait for every outstanding result, plus the sequencer tail
  task automatic drain();
    in_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // write the rate window while the block is idle
  task automatic write_window(logic [31:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    win_us = value;
    @(posedge clk);
  endtask

  function automatic meter_req_t make_req(ctmt_pkg::req_t t, int s, logic [30:0] cnt,
                                          logic [62:0] now);
    meter_req_t r;
    r.req = t;
    r.slot = 4'(s);
    r.count = cnt;
    r.kind = 3'($urandom_range(0, 7));
    r.chan = 8'($urandom_range(0, 255));
    r.ip = $urandom;
    r.port = 16'($urandom_range(0, 65535));
    r.now = now;
    return r;
  endfunction

  // random request with a time base that mostly moves forward
  function automatic meter_req_t random_req(int query_pct);
    int          pick;
    logic [30:0] cnt;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 99)) inside
      [0:1]:   cur_now = 63'({$urandom, $urandom});
      [2:4]:   cur_now = cur_now - $urandom_range(0, 2000000);
      default: cur_now = cur_now + $urandom_range(0, 400000);
    endcase
    case ($urandom_range(0, 19))
      0:       cnt = '0;
      1:       cnt = 31'($urandom);
      default: cnt = 31'($urandom_range(1, 20000));
    endcase
    if (pick < 12) return make_req(ctmt_pkg::REQ_ADD, 0, 31'($urandom), cur_now);
    if (pick < 20)
      return make_req(ctmt_pkg::REQ_DEL, $urandom_range(0, 15), 31'($urandom), cur_now);
    if (pick < 100 - query_pct)
      return make_req(ctmt_pkg::REQ_BYTES, $urandom_range(0, 15), cnt, cur_now);
    return make_req(ctmt_pkg::REQ_QUERY, $urandom_range(0, 15), 31'($urandom), cur_now);
  endfunction

  task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      errors++;
      $display("%0t: %s mismatch expected 0x%0h actual 0x%0h", $time, name, exp, act);
    end
  endtask

  // result receiver: random stalls, optional long hold-off, in-order check
  initial begin
    meter_res_t exp;
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall > 0) begin
        if (out_ch.ready) out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status %0d slot %0d", $time,
                 out_ch.status, out_ch.result_slot);
      end else begin
        exp = pending_results.pop_front();
        check_field("status", exp.status, out_ch.status);
        check_field("result_slot", exp.slot, out_ch.result_slot);
        check_field("in_use", exp.in_use, out_ch.in_use);
        check_field("kind_out", exp.kind, out_ch.kind_out);
        check_field("channel_out", exp.chan, out_ch.channel_out);
        check_field("ip_out", exp.ip, out_ch.ip_out);
        check_field("port_out", exp.port, out_ch.port_out);
        check_field("connected_s", exp.secs, out_ch.connected_s);
        check_field("rate_kbps", exp.rate, out_ch.rate_kbps);
        check_field("total_bytes", exp.total, out_ch.total_bytes);
      end
    end
  end

  // fill the table, hit table full, free and reuse a slot
  task automatic test_fill_and_full();
    for (int i = 0; i < SLOTS; i++)
      send_req(make_req(ctmt_pkg::REQ_ADD, 0, '0, 63'(i) * 63'd1000));
    send_req(make_req(ctmt_pkg::REQ_ADD, 0, '0, 63'd50000));
    send_req(make_req(ctmt_pkg::REQ_DEL, 3, '0, 63'd60000));
    send_req(make_req(ctmt_pkg::REQ_DEL, 3, '0, 63'd60000));
    send_req(make_req(ctmt_pkg::REQ_BYTES, 3, 31'd777, 63'd61000));
    send_req(make_req(ctmt_pkg::REQ_QUERY, 3, '0, 63'd62000));
    send_req(make_req(ctmt_pkg::REQ_ADD, 0, '0, NOW_MASK));
  endtask

  // byte counts at the extremes, rate update, time running backwards
  task automatic test_bytes_and_rate();
    send_req(make_req(ctmt_pkg::REQ_BYTES, 5, 31'd0, 63'd0));
    send_req(make_req(ctmt_pkg::REQ_BYTES, 5, {31{1'b1}}, 63'd0));
    send_req(make_req(ctmt_pkg::REQ_BYTES, 15, 31'd1, 63'd0));
    send_req(make_req(ctmt_pkg::REQ_QUERY, 5, '0, 63'd5000 + 63'd2000000));
    send_req(make_req(ctmt_pkg::REQ_QUERY, 5, '0, 63'd100));
    send_req(make_req(ctmt_pkg::REQ_QUERY, 15, '0, 63'd15000 + 63'd999999));
    send_req(make_req(ctmt_pkg::REQ_QUERY, 15, '0, 63'd15000 + 63'd1000000));
    send_req(make_req(ctmt_pkg::REQ_QUERY, 3, '0, NOW_MASK));
  endtask

  // window register at its extremes and a small value
  task automatic test_window_settings();
    write_window(32'd0);
    send_req(make_req(ctmt_pkg::REQ_BYTES, 7, 31'd4096, 63'd0));
    send_req(make_req(ctmt_pkg::REQ_QUERY, 7, '0, 63'd7001));
    write_window(32'hFFFF_FFFF);
    send_req(make_req(ctmt_pkg::REQ_BYTES, 7, 31'd4096, 63'd0));
    send_req(make_req(ctmt_pkg::REQ_QUERY, 7, '0, 63'd7001 + 63'hFFFF_FFFE));
    send_req(make_req(ctmt_pkg::REQ_QUERY, 7, '0, 63'd7001 + 63'hFFFF_FFFF));
    write_window(32'd1);
  endtask

  task automatic test_random_traffic(int n, int query_pct);
    repeat (n) send_req(random_req(query_pct), $urandom_range(0, 4) == 0);
  endtask

  // stall results for a long stretch while requests keep coming
  task automatic test_backpressure();
    hold_off_cycles = 2000;
    repeat (40) send_req(random_req(10), 1);
  endtask

  // sender waits for every result before going on
  task automatic test_sender_pause();
    repeat (20) send_req(random_req(20));
    in_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) send_req(random_req(20));
  endtask

  initial begin
    errors = 0;
    hold_off_cycles = 0;
    cur_now = 63'd100000;
    win_us = ctmt_pkg::WINDOW_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      tb_used[i] = 1'b0;
      tb_kind[i] = '0;
      tb_chan[i] = '0;
      tb_ip[i] = '0;
      tb_port[i] = '0;
      tb_conn[i] = '0;
      tb_total[i] = '0;
      tb_bbase[i] = '0;
      tb_tbase[i] = '0;
      tb_rate[i] = '0;
    end
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = ctmt_pkg::REQ_ADD;
    in_ch.slot = '0;
    in_ch.byte_count = '0;
    in_ch.client_kind = '0;
    in_ch.channel = '0;
    in_ch.peer_ip = '0;
    in_ch.peer_port = '0;
    in_ch.now_us = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_and_full();
    test_bytes_and_rate();
    test_window_settings();
    test_random_traffic(500, 15);
    write_window(32'd250000);
    test_backpressure();
    test_random_traffic(500, 15);
    write_window(ctmt_pkg::WINDOW_RESET);
    test_sender_pause();
    test_random_traffic(550, 20);

    drain();
    if (errors == 0) begin
      $display("client_traffic_meter_table_test passed");
    end else begin
      $display("client_traffic_meter_table_test failed");
    end
    $finish;
  end

endmodule
